/* design/mtg_pkg.sv */
`timescale 1ns / 1ps

package mtg_pkg;

  // Item and store geometry that does not depend on the frame size.
  localparam int ADDR_W       = 13;
  localparam int DATA_W       = 8;
  localparam int LIMIT_W      = 16;
  localparam int IMG_SIZE     = 1024;
  localparam int IMG_ADDR_W   = 10;
  localparam int COL_W        = 5;
  localparam int OVL_PAIRS    = 16;
  localparam int PAIR_W       = 4;
  localparam int OVL_BYTES    = 60;
  localparam int OFF_W        = 6;
  localparam int OVL_SHIFT    = 12;
  localparam int ROW_MAX      = 255;
  localparam int RESULT_DEPTH = 16;
  localparam int RESULT_PTR_W = 4;
  localparam int REG_ADDR_W   = 4;
  localparam int APB_DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_WRITE_MONO  = 2'd0,
    OP_WRITE_IMAGE = 2'd1,
    OP_READ_GREY   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_OVERLAY_SHOWN = 2'd0,
    REG_IMAGE_VALID   = 2'd1,
    REG_IMAGE_COL     = 2'd2,
    REG_IMAGE_ROW     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } cmd_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] grey_byte;
  } result_item_t;

  typedef struct packed {
    logic       overlay_shown;
    logic       image_valid;
    logic [7:0] image_col;
    logic [7:0] image_row;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [PAIR_W-1:0] pair;
    logic [OFF_W-1:0]  offset;
  } ovl_match_t;

endpackage

/* design/mtg_stream_if.sv */
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload word per transaction.
interface mtg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/mtg_regs.sv */
`timescale 1ns / 1ps

module mtg_regs
  import mtg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_index_t index;
  logic       wr_en;

  assign pready = 1'b1;
  assign index  = reg_index_t'(paddr[REG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (index)
        REG_OVERLAY_SHOWN: cfg.overlay_shown <= pwdata[0];
        REG_IMAGE_VALID:   cfg.image_valid   <= pwdata[0];
        REG_IMAGE_COL:     cfg.image_col     <= pwdata[7:0];
        REG_IMAGE_ROW:     cfg.image_row     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register.
  always_comb begin
    prdata = '0;
    case (index)
      REG_OVERLAY_SHOWN: prdata[0]   = cfg.overlay_shown;
      REG_IMAGE_VALID:   prdata[0]   = cfg.image_valid;
      REG_IMAGE_COL:     prdata[7:0] = cfg.image_col;
      REG_IMAGE_ROW:     prdata[7:0] = cfg.image_row;
      default:           prdata      = '0;
    endcase
  end

endmodule

/* design/mtg_overlay.sv */
`timescale 1ns / 1ps

module mtg_overlay
  import mtg_pkg::*;
#(
  parameter int FRAME_WIDTH = 212
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic [ADDR_W-1:0] addr,
  output ovl_match_t        match
);

  localparam int SPAN_W = $clog2((ROW_MAX + 2 * OVL_PAIRS) * FRAME_WIDTH + 1);
  localparam int BASE_W = SPAN_W;

  logic [SPAN_W-1:0] row_w;
  logic [7:0]        col;
  logic              enable;
  logic [BASE_W-1:0] base [OVL_PAIRS];
  logic [BASE_W-1:0] addr_ext;

  assign addr_ext = BASE_W'(addr);

  // The overlay is shown only when both flags are set.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else begin
      enable <= cfg.overlay_shown && cfg.image_valid;
    end
  end

  // First stage: starting row times frame width.
  always_ff @(posedge clk) begin
    row_w <= SPAN_W'(cfg.image_row) * SPAN_W'(FRAME_WIDTH);
    col   <= cfg.image_col;
  end

  // Second stage: start offset of every row pair of the window.
  always_ff @(posedge clk) begin
    for (int i = 0; i < OVL_PAIRS; i++) begin
      base[i] <= BASE_W'((row_w + SPAN_W'(2 * i * FRAME_WIDTH)) >> 1)
                 + BASE_W'(col) + BASE_W'(OVL_SHIFT);
    end
  end

  // Window lookup; the lowest row pair wins where windows overlap.
  always_comb begin
    match = '0;
    for (int i = OVL_PAIRS - 1; i >= 0; i--) begin
      if (enable && (addr_ext >= base[i])
          && ({1'b0, addr_ext} < ({1'b0, base[i]} + (BASE_W + 1)'(OVL_BYTES)))) begin
        match.hit    = 1'b1;
        match.pair   = PAIR_W'(i);
        match.offset = OFF_W'(addr_ext - base[i]);
      end
    end
  end

endmodule

/* design/mtg_frame_pipe.sv */
`timescale 1ns / 1ps

module mtg_frame_pipe
  import mtg_pkg::*;
#(
  parameter int FRAME_WIDTH  = 212,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cmd_item_t         in_item,
  output logic [ADDR_W-1:0] ovl_addr,
  input  ovl_match_t        ovl_match,
  output logic              res_valid,
  output logic [DATA_W-1:0] res_byte
);

  localparam int PAGES       = (FRAME_HEIGHT + 7) / 8;
  localparam int BANDS       = (FRAME_HEIGHT + 1) / 2;
  localparam int MONO_SIZE   = FRAME_WIDTH * PAGES;
  localparam int GREY_SIZE   = FRAME_WIDTH * BANDS;
  localparam int MIDX_W      = $clog2(MONO_SIZE);
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (1 << RECIP_SHIFT) / FRAME_WIDTH;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int W_BITS      = $clog2(FRAME_WIDTH + 1);
  localparam int Q_W         = $clog2(((1 << ADDR_W) - 1) / FRAME_WIDTH + 2);
  localparam int X_W         = $clog2(FRAME_WIDTH);
  localparam int ZPAD_W      = LIMIT_W - ADDR_W;

  // Control and payload of each stage.
  logic v0, v1, v2, v3, v4, rd5;
  logic [1:0]        op0, op1, op2, op3, op4;
  logic [ADDR_W-1:0] addr0, addr1, addr2, addr3, addr4;
  logic [DATA_W-1:0] data0, data1, data2, data3, data4;
  logic [Q_W-1:0]    q1, q2;
  logic [ADDR_W-1:0] qw2;
  logic [Q_W-1:0]    band3;
  logic [X_W-1:0]    x3;
  logic              gin3;
  ovl_match_t        match3;
  logic [MIDX_W-1:0] midx4;
  logic [1:0]        pos4, pos5;
  logic              hit4, hit5, odd4, odd5, range4, range5;
  logic [IMG_ADDR_W-1:0] ia4, ib4;
  logic [DATA_W-1:0] mono_q, img_b, img_b1;

  logic [DATA_W-1:0] mono_mem [MONO_SIZE];
  logic [DATA_W-1:0] img_mem [IMG_SIZE];

  // Combinational terms between the stages.
  logic [ADDR_W+RECIP_W-1:0] recip_prod;
  logic [Q_W+W_BITS-1:0]     qw_prod;
  logic [ADDR_W-1:0]         rem;
  logic                      rem_fix;
  logic [LIMIT_W-1:0]        midx_full;
  logic [COL_W-1:0]          img_col;
  logic [2:0]                bit_lo;
  logic [2:0]                bit_hi;

  assign recip_prod = addr0 * RECIP_W'(RECIP);
  assign qw_prod    = q1 * W_BITS'(FRAME_WIDTH);
  assign rem        = addr2 - qw2;
  assign rem_fix    = rem >= ADDR_W'(FRAME_WIDTH);
  assign ovl_addr   = addr2;
  assign midx_full  = LIMIT_W'(band3 >> 2) * LIMIT_W'(FRAME_WIDTH) + LIMIT_W'(x3);
  assign img_col    = COL_W'(1) + COL_W'(match3.offset[OFF_W-1:1]);

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      rd5 <= 1'b0;
    end else begin
      v0  <= in_valid;
      v1  <= v0;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      rd5 <= v4 && (op4 == OP_READ_GREY);
    end
  end

  // Address split into band and column, then window and store addresses.
  always_ff @(posedge clk) begin
    if (in_valid) begin
      op0   <= in_item.operation;
      addr0 <= in_item.address;
      data0 <= in_item.data;
    end
    // Estimate of address / width, at most one short.
    op1   <= op0;
    addr1 <= addr0;
    data1 <= data0;
    q1    <= Q_W'(recip_prod >> RECIP_SHIFT);
    // Product of the estimate and the width.
    op2   <= op1;
    addr2 <= addr1;
    data2 <= data1;
    q2    <= q1;
    qw2   <= ADDR_W'(qw_prod);
    // Correct the estimate and look up the overlay window.
    op3    <= op2;
    addr3  <= addr2;
    data3  <= data2;
    band3  <= rem_fix ? q2 + Q_W'(1) : q2;
    x3     <= X_W'(rem_fix ? rem - ADDR_W'(FRAME_WIDTH) : rem);
    gin3   <= {ZPAD_W'(0), addr2} < LIMIT_W'(GREY_SIZE);
    match3 <= ovl_match;
    // Mono frame byte index and the two image rows, flipped vertically.
    op4    <= op3;
    addr4  <= addr3;
    data4  <= data3;
    midx4  <= MIDX_W'(midx_full);
    range4 <= gin3 && (midx_full < LIMIT_W'(MONO_SIZE));
    pos4   <= band3[1:0];
    hit4   <= gin3 && match3.hit;
    odd4   <= match3.offset[0];
    ia4    <= {~match3.pair, 1'b1, img_col};
    ib4    <= {~match3.pair, 1'b0, img_col};
    // Side information for the output byte.
    pos5   <= pos4;
    hit5   <= hit4;
    odd5   <= odd4;
    range5 <= range4;
  end

  // Mono frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (v4 && (op4 == OP_WRITE_MONO) && ({ZPAD_W'(0), addr4} < LIMIT_W'(MONO_SIZE))) begin
      mono_mem[MIDX_W'(addr4)] <= data4;
    end
    mono_q <= mono_mem[midx4];
  end

  // Image store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (v4 && (op4 == OP_WRITE_IMAGE) && ({ZPAD_W'(0), addr4} < LIMIT_W'(IMG_SIZE))) begin
      img_mem[addr4[IMG_ADDR_W-1:0]] <= data4;
    end
    img_b  <= img_mem[ia4];
    img_b1 <= img_mem[ib4];
  end

  // Upper pixel of the pair goes to the low nibble, lower pixel to the high.
  assign bit_lo    = {pos5, 1'b0};
  assign bit_hi    = {pos5, 1'b1};
  assign res_valid = rd5;

  always_comb begin
    if (!range5) begin
      res_byte = '0;
    end else if (hit5) begin
      res_byte = odd5 ? {img_b1[3:0], img_b[3:0]} : {img_b1[7:4], img_b[7:4]};
    end else begin
      res_byte = {{4{mono_q[bit_hi]}}, {4{mono_q[bit_lo]}}};
    end
  end

endmodule

/* design/mtg_result_fifo.sv */
`timescale 1ns / 1ps

module mtg_result_fifo
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head
);

  logic [DATA_W-1:0]       entry [RESULT_DEPTH];
  logic [RESULT_PTR_W-1:0] wr_ptr;
  logic [RESULT_PTR_W-1:0] rd_ptr;
  logic [RESULT_PTR_W:0]   count;

  assign not_empty = count != '0;
  assign head      = entry[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (RESULT_PTR_W + 1)'(push) - (RESULT_PTR_W + 1)'(pop);
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

/* design/mono_to_grey_frame_converter.sv */
`timescale 1ns / 1ps

// Monochrome page frame to 4-bit greyscale converter.
// Command channel (cmd): operation 0 writes a byte of the 1-bit page frame,
// operation 1 writes a byte of the 32x32 image, operation 2 reads one byte of
// the converted grey frame, operation 3 is ignored. Only reads produce a
// transaction on the result channel (rsp), in command order.
// One command is taken every clock cycle while cmd.ready is high. A read result
// reaches rsp through a fixed six-stage pipeline (address split into band and
// column, overlay window lookup, store read) feeding a 16-entry result queue.
// When the receiver stalls, results collect in the queue; cmd.ready drops once
// 16 reads are outstanding and rises again as results are taken.
// Reset clears the pipeline, the queue and the overlay registers. The two
// stores are not cleared: an entry must be written before it is read.
// Overlay registers on the APB port take effect for commands accepted in the
// same cycle as the write or later.

module mono_to_grey_frame_converter
  import mtg_pkg::*;
#(
  parameter int FRAME_WIDTH  = 212,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  mtg_stream_if.sink            cmd,
  mtg_stream_if.source          rsp
);

  localparam int PEND_W = $clog2(RESULT_DEPTH + 1);

  cfg_t              cfg;
  ovl_match_t        ovl_match;
  logic [ADDR_W-1:0] ovl_addr;
  logic              cmd_fire;
  logic              rsp_fire;
  logic              read_fire;
  logic              res_valid;
  logic [DATA_W-1:0] res_byte;
  logic [DATA_W-1:0] head;
  logic [PEND_W-1:0] pending;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign rsp_fire  = rsp.valid && rsp.ready;
  assign read_fire = cmd_fire && (cmd.payload.operation == OP_READ_GREY);
  assign cmd.ready = pending < PEND_W'(RESULT_DEPTH);
  assign rsp.payload.grey_byte = head;

  // Reads in flight or waiting in the queue; bounds the queue fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_W'(read_fire) - PEND_W'(rsp_fire);
    end
  end

  mtg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtg_overlay #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_overlay (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .addr  (ovl_addr),
    .match (ovl_match)
  );

  mtg_frame_pipe #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_fire),
    .in_item   (cmd.payload),
    .ovl_addr  (ovl_addr),
    .ovl_match (ovl_match),
    .res_valid (res_valid),
    .res_byte  (res_byte)
  );

  mtg_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_byte),
    .pop       (rsp_fire),
    .not_empty (rsp.valid),
    .head      (head)
  );

endmodule

/* tb/mono_to_grey_frame_converter_test.sv */
`timescale 1ns / 1ps

module mono_to_grey_frame_converter_test;
  import mtg_pkg::*;

  localparam int FRAME_WIDTH   = 212;
  localparam int FRAME_HEIGHT  = 64;
  localparam int MONO_SIZE     = FRAME_WIDTH * ((FRAME_HEIGHT + 7) / 8);
  localparam int GREY_SIZE     = FRAME_WIDTH * ((FRAME_HEIGHT + 1) / 2);
  localparam int ADDR_LIMIT    = 1 << ADDR_W;
  localparam int IMG_ROW_BYTES = 32;
  localparam int IMG_LAST_ROW  = 31;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int PIPE_LATENCY    = 6;
  localparam int DRAIN_CYCLES    = 4 * PIPE_LATENCY;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_TRIGGER    = 300;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int REPORT_LINES    = 100;

  typedef struct {
    int unsigned       address;
    logic [DATA_W-1:0] grey_byte;
  } grey_expect_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mtg_stream_if #(.payload_t(cmd_item_t))    cmd_ch ();
  mtg_stream_if #(.payload_t(result_item_t)) rsp_ch ();

  mono_to_grey_frame_converter #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cmd    (cmd_ch),
    .rsp    (rsp_ch)
  );

  // Shadow copy of the two stores and the overlay registers.
  logic [7:0] mono_mem  [MONO_SIZE];
  logic [7:0] image_mem [IMG_SIZE];
  cfg_t       frame_cfg;

  // Entries that the generated stream has written so far.
  bit mono_filled  [MONO_SIZE];
  bit image_filled [IMG_SIZE];

  cmd_item_t    pending_cmds[$];
  grey_expect_t grey_expected[$];
  grey_expect_t oldest_grey;

  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned grey_checked = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  bit          hold_done;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= REPORT_LINES) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Grey offset where overlay row pair starts under the current registers.
  function automatic int overlay_base(int pair);
    return ((int'(frame_cfg.image_row) + 2 * pair) * FRAME_WIDTH) / 2 +
           int'(frame_cfg.image_col) + OVL_SHIFT;
  endfunction

  // Finds the overlay row pair and byte offset covering a grey address.
  function automatic bit overlay_slot(int a, output int pair, output int offset);
    int base;
    pair   = 0;
    offset = 0;
    if (!(frame_cfg.overlay_shown && frame_cfg.image_valid)) return 1'b0;
    for (int i = 0; i < OVL_PAIRS; i++) begin
      base = overlay_base(i);
      if (a >= base && a < base + OVL_BYTES) begin
        pair   = i;
        offset = a - base;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int mono_index(int a);
    return ((2 * (a / FRAME_WIDTH)) / 8) * FRAME_WIDTH + a % FRAME_WIDTH;
  endfunction

  function automatic int image_index(int pair, int offset, int upper);
    return (IMG_LAST_ROW - upper - 2 * pair) * IMG_ROW_BYTES + 1 + offset / 2;
  endfunction

  // Computes the converted grey byte at a linear address.
  function automatic logic [7:0] grey_for_address(int a);
    int         pair;
    int         offset;
    int         y;
    int         bitpos;
    logic [7:0] lower_row;
    logic [7:0] upper_row;
    logic [7:0] page_byte;
    logic [7:0] grey;
    grey = 8'h00;
    if (a >= GREY_SIZE) return grey;
    if (overlay_slot(a, pair, offset)) begin
      lower_row = image_mem[image_index(pair, offset, 0)];
      upper_row = image_mem[image_index(pair, offset, 1)];
      if (offset % 2 == 0) return (upper_row & 8'hF0) | (lower_row >> 4);
      return {upper_row[3:0], lower_row[3:0]};
    end
    y         = 2 * (a / FRAME_WIDTH);
    bitpos    = y % 8;
    page_byte = mono_mem[mono_index(a)];
    if (page_byte[bitpos]) grey[3:0] = 4'hF;
    if (page_byte[bitpos + 1]) grey[7:4] = 4'hF;
    return grey;
  endfunction

  // Applies one accepted command to the shadow state.
  function automatic void apply_command(cmd_item_t item);
    grey_expect_t entry;
    case (op_t'(item.operation))
      OP_WRITE_MONO: begin
        if (item.address < MONO_SIZE) mono_mem[item.address] = item.data;
      end
      OP_WRITE_IMAGE: begin
        if (item.address < IMG_SIZE) image_mem[item.address] = item.data;
      end
      OP_READ_GREY: begin
        entry.address   = item.address;
        entry.grey_byte = grey_for_address(int'(item.address));
        grey_expected.push_back(entry);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] op, int a, logic [7:0] d);
    cmd_item_t item;
    item.operation = op;
    item.address   = a[ADDR_W-1:0];
    item.data      = d;
    if (op == OP_WRITE_MONO && a < MONO_SIZE) mono_filled[a] = 1'b1;
    if (op == OP_WRITE_IMAGE && a < IMG_SIZE) image_filled[a] = 1'b1;
    pending_cmds.push_back(item);
    items_queued++;
  endfunction

  // Queues a read, first filling any store entry it depends on.
  function automatic void queue_read(int a);
    int pair;
    int offset;
    int idx;
    if (a < GREY_SIZE) begin
      idx = mono_index(a);
      if (!mono_filled[idx]) queue_item(OP_WRITE_MONO, idx, random_byte());
      if (overlay_slot(a, pair, offset)) begin
        for (int upper = 0; upper < 2; upper++) begin
          idx = image_index(pair, offset, upper);
          if (!image_filled[idx]) queue_item(OP_WRITE_IMAGE, idx, random_byte());
        end
      end
    end
    queue_item(OP_READ_GREY, a, random_byte());
  endfunction

  // Queues one random command; returns 0 when the block would ignore it.
  function automatic bit random_item();
    int pick;
    int a;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      pick = $urandom_range(0, 99);
      if (frame_cfg.overlay_shown && frame_cfg.image_valid && pick < 50) begin
        a = overlay_base($urandom_range(0, OVL_PAIRS - 1)) + int'($urandom_range(0, 63)) - 2;
        a = a % ADDR_LIMIT;
      end else if (pick < 60) begin
        a = $urandom_range(GREY_SIZE, ADDR_LIMIT - 1);
      end else begin
        a = $urandom_range(0, GREY_SIZE - 1);
      end
      queue_read(a);
      return 1'b1;
    end
    if (pick < 68) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(OP_WRITE_MONO, $urandom_range(MONO_SIZE, ADDR_LIMIT - 1), random_byte());
        return 1'b0;
      end
      queue_item(OP_WRITE_MONO, $urandom_range(0, MONO_SIZE - 1), random_byte());
      return 1'b1;
    end
    if (pick < 92) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(OP_WRITE_IMAGE, $urandom_range(IMG_SIZE, ADDR_LIMIT - 1), random_byte());
        return 1'b0;
      end
      queue_item(OP_WRITE_IMAGE, $urandom_range(0, IMG_SIZE - 1), random_byte());
      return 1'b1;
    end
    queue_item(OP_UNUSED, $urandom_range(0, ADDR_LIMIT - 1), random_byte());
    return 1'b0;
  endfunction

  // APB write: setup cycle, then access cycle.
  task automatic write_register(reg_index_t index, logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_OVERLAY_SHOWN: frame_cfg.overlay_shown = value[0];
      REG_IMAGE_VALID:   frame_cfg.image_valid   = value[0];
      REG_IMAGE_COL:     frame_cfg.image_col     = value;
      REG_IMAGE_ROW:     frame_cfg.image_row     = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_overlay(logic shown, logic valid, logic [7:0] col, logic [7:0] row);
    write_register(REG_OVERLAY_SHOWN, {7'd0, shown});
    write_register(REG_IMAGE_VALID, {7'd0, valid});
    write_register(REG_IMAGE_COL, col);
    write_register(REG_IMAGE_ROW, row);
  endtask

  // Holds off until every queued command is taken and every read answered.
  task automatic wait_for_drain();
    do begin
      @(posedge clk);
    end while (items_taken != items_queued || grey_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Command driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (gap_left > 0) begin
        cmd_ch.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= pending_cmds.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall patterns that change now and then, plus one long hold.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_mode   <= 0;
      mode_left    <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && grey_checked >= HOLD_TRIGGER &&
                 items_queued - items_taken > 20) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      hold_done    <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(30, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Monitor: check each result transaction, then record each command transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (grey_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected grey byte %02h", rsp_ch.payload.grey_byte));
        end else begin
          oldest_grey = grey_expected.pop_front();
          if (rsp_ch.payload.grey_byte !== oldest_grey.grey_byte) begin
            report_mismatch($sformatf("grey byte at address %0d: got %02h, want %02h",
                                      oldest_grey.address, rsp_ch.payload.grey_byte,
                                      oldest_grey.grey_byte));
          end
        end
        grey_checked++;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        apply_command(cmd_ch.payload);
        items_taken++;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int counted;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    frame_cfg      = '0;
    rst            = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Plain conversion: store extremes, ignored writes, bit pairs of one page.
    set_overlay(1'b0, 1'b0, 8'd0, 8'd0);
    queue_item(OP_WRITE_MONO, 0, 8'h96);
    queue_item(OP_WRITE_MONO, MONO_SIZE - 1, 8'hFF);
    queue_item(OP_WRITE_MONO, MONO_SIZE, 8'h00);
    queue_item(OP_WRITE_MONO, ADDR_LIMIT - 1, 8'h00);
    queue_item(OP_WRITE_IMAGE, 0, 8'h00);
    queue_item(OP_WRITE_IMAGE, IMG_SIZE - 1, 8'hFF);
    queue_item(OP_WRITE_IMAGE, IMG_SIZE, 8'h5A);
    queue_item(OP_UNUSED, ADDR_LIMIT - 1, 8'hFF);
    for (int band = 0; band < 4; band++) queue_read(band * FRAME_WIDTH);
    queue_read(GREY_SIZE - 1);
    queue_read(GREY_SIZE);
    queue_read(ADDR_LIMIT - 1);
    wait_for_drain();

    // Overlay at the origin: window edges of the first and last row pair.
    set_overlay(1'b1, 1'b1, 8'd0, 8'd0);
    queue_read(OVL_SHIFT - 1);
    queue_read(OVL_SHIFT);
    queue_read(OVL_SHIFT + 1);
    queue_read(OVL_SHIFT + OVL_BYTES - 1);
    queue_read(OVL_SHIFT + OVL_BYTES);
    queue_read(overlay_base(OVL_PAIRS - 1));
    queue_read(overlay_base(OVL_PAIRS - 1) + OVL_BYTES - 1);
    wait_for_drain();

    // Random phases, each under its own overlay setting.
    // Every queued transaction counts toward the phase size, fill writes included.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_overlay(1'b1, 1'b1, 8'd0, 8'd0);
        1: set_overlay(1'b1, 1'b1, 8'd255, 8'd255);
        2: set_overlay(1'b1, 1'b0, 8'($urandom), 8'($urandom_range(0, 40)));
        3: set_overlay(1'b0, 1'b1, 8'($urandom), 8'($urandom_range(0, 40)));
        4: set_overlay(1'b1, 1'b1, 8'd255, 8'd0);
        5: set_overlay(1'b1, 1'b1, 8'd0, 8'd50);
        8: set_overlay(1'b0, 1'b0, 8'($urandom), 8'($urandom));
        default: set_overlay(1'b1, 1'b1, 8'($urandom), 8'($urandom_range(0, 60)));
      endcase
      counted = int'(items_queued);
      while (int'(items_queued) - counted < ITEMS_PER_PHASE) void'(random_item());
      wait_for_drain();
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
